[design/uvs_pkg.sv]
// Package for the UV sphere vertex and triangle generator.
// Shared constants, queue item type and fixed-point helper functions.
// No dependencies.
package uvs_pkg;

  localparam int MAX_STACKS  = 128;
  localparam int MAX_SECTORS = 128;
  localparam int FRAC_BITS   = 15;
  localparam int Q_BITS      = 30;
  localparam int POS_SHIFT   = 2 * Q_BITS - FRAC_BITS;
  localparam int Y_SHIFT     = Q_BITS - FRAC_BITS;

  localparam logic [7:0] STACK_COUNT_RESET  = 8'd16;
  localparam logic [7:0] SECTOR_COUNT_RESET = 8'd32;
  localparam logic [7:0] STACK_MIN          = 8'd2;
  localparam logic [7:0] SECTOR_MIN         = 8'd3;
  localparam logic [7:0] STACK_MAX          = 8'(MAX_STACKS);
  localparam logic [7:0] SECTOR_MAX         = 8'(MAX_SECTORS);

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STACK_COUNT  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SECTOR_COUNT = 1'b1;

  // series and angle constants
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [3:0]  LAST_TERM   = 4'd9;

  // long division: 40-bit numerators, 4 quotient bits per cycle
  localparam int DIV_W      = 40;
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = DIV_W / DIV_STEP;
  localparam int DIV_LANES  = 4;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  localparam int TDATA_W = 128;

  typedef struct packed {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [7:0]  stacks;
    logic [7:0]  sectors;
    logic        tri_a;
    logic        tri_b;
    logic [14:0] k1;
    logic [14:0] k2;
  } uvs_item_t;

  // sine series divisor (2k+2)(2k+3)
  function automatic logic [8:0] sin_div(input logic [3:0] k);
    case (k)
      4'd0: return 9'd6;
      4'd1: return 9'd20;
      4'd2: return 9'd42;
      4'd3: return 9'd72;
      4'd4: return 9'd110;
      4'd5: return 9'd156;
      4'd6: return 9'd210;
      4'd7: return 9'd272;
      default: return 9'd342;
    endcase
  endfunction

  // floor(2^32 / sin_div)
  function automatic logic [31:0] sin_recip(input logic [3:0] k);
    case (k)
      4'd0: return 32'd715827882;
      4'd1: return 32'd214748364;
      4'd2: return 32'd102261126;
      4'd3: return 32'd59652323;
      4'd4: return 32'd39045157;
      4'd5: return 32'd27531841;
      4'd6: return 32'd20452225;
      4'd7: return 32'd15790320;
      default: return 32'd12558383;
    endcase
  endfunction

  // cosine series divisor (2k+1)(2k+2)
  function automatic logic [8:0] cos_div(input logic [3:0] k);
    case (k)
      4'd0: return 9'd2;
      4'd1: return 9'd12;
      4'd2: return 9'd30;
      4'd3: return 9'd56;
      4'd4: return 9'd90;
      4'd5: return 9'd132;
      4'd6: return 9'd182;
      4'd7: return 9'd240;
      default: return 9'd306;
    endcase
  endfunction

  function automatic logic [31:0] cos_recip(input logic [3:0] k);
    case (k)
      4'd0: return 32'd2147483648;
      4'd1: return 32'd357913941;
      4'd2: return 32'd143165576;
      4'd3: return 32'd76695844;
      4'd4: return 32'd47721858;
      4'd5: return 32'd32537631;
      4'd6: return 32'd23598721;
      4'd7: return 32'd17895697;
      default: return 32'd14035840;
    endcase
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    if (v > 34'sd1073741824) return 32'sd1073741824;
    else if (v < -34'sd1073741824) return -32'sd1073741824;
    else return signed'(v[31:0]);
  endfunction

  // rounded magnitude plus sign to saturated 16-bit two's complement
  function automatic logic [15:0] round_sat16(input logic [16:0] mag, input logic neg);
    logic [16:0] lim;
    logic [16:0] res;
    if (neg) begin
      lim = (mag > 17'd32768) ? 17'd32768 : mag;
      res = 17'd0 - lim;
    end else begin
      res = (mag > 17'd32767) ? 17'd32767 : mag;
    end
    return res[15:0];
  endfunction

endpackage

[design/uvs_front.sv]
// Front end: configuration registers, grid point range check and triangle
// classification. Pushes in-range points into the queue. Uses uvs_pkg.
module uvs_front import uvs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]            cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_row,
  input  logic [7:0]            in_col,
  input  logic                  q_ready,
  output logic                  push,
  output uvs_item_t             item
);

  logic [7:0]  stack_count;
  logic [7:0]  sector_count;
  logic [7:0]  s_eff;
  logic [7:0]  t_eff;
  logic        in_range;
  logic        tri_ok;
  logic [15:0] row_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count  <= STACK_COUNT_RESET;
      sector_count <= SECTOR_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_STACK_COUNT:  stack_count  <= cfg_wdata;
        CFG_SECTOR_COUNT: sector_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    s_eff = (stack_count < STACK_MIN) ? STACK_MIN :
            (stack_count > STACK_MAX) ? STACK_MAX : stack_count;
    t_eff = (sector_count < SECTOR_MIN) ? SECTOR_MIN :
            (sector_count > SECTOR_MAX) ? SECTOR_MAX : sector_count;
    in_range = (in_row <= s_eff) && (in_col <= t_eff);
    tri_ok   = (in_row < s_eff) && (in_col < t_eff);
    // T+1 <= 129 fits in 8 bits
    row_base = in_row * (t_eff + 8'd1);

    item.row     = in_row;
    item.col     = in_col;
    item.stacks  = s_eff;
    item.sectors = t_eff;
    item.tri_a   = tri_ok && (in_row != 8'd0);
    item.tri_b   = tri_ok && (in_row != s_eff - 8'd1);
    item.k1      = row_base[14:0] + {7'd0, in_col};
    item.k2      = item.k1 + {7'd0, t_eff} + 15'd1;
  end

  // out-of-range points are accepted and dropped
  assign in_ready = q_ready;
  assign push     = in_valid && q_ready && in_range;

endmodule

[design/uvs_fifo.sv]
// Short queue between front and back end, holding classified grid points.
// Uses uvs_pkg for the item type and depth.
module uvs_fifo import uvs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  uvs_item_t push_item,
  output logic      ready,
  input  logic      pop,
  output uvs_item_t pop_item,
  output logic      valid
);

  uvs_item_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_PTR_W:0]     count;
  logic                    do_push;
  logic                    do_pop;

  assign ready    = (count != FIFO_PTR_W'(0) + (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign valid    = (count != '0);
  assign pop_item = mem[rd_ptr];
  assign do_push  = push && ready;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (FIFO_PTR_W+1)'(1);
        2'b01:   count <= count - (FIFO_PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[design/uvs_trig.sv]
// Sine and cosine of a Q0.32 turn fraction by a ten-term Taylor series,
// each term computed in turn by multiply, reciprocal estimate and correction.
// Uses uvs_pkg for divisor tables and clamping.
module uvs_trig import uvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        phase,
  output logic               done,
  output logic signed [31:0] sin_q30,
  output logic signed [31:0] cos_q30
);

  typedef enum logic [2:0] {T_IDLE, T_X, T_SQ, T_ADD, T_EST, T_COR, T_FIN} trig_state_t;

  trig_state_t        state;
  logic [1:0]         quad;
  logic [29:0]        rr;
  logic [30:0]        x;
  logic [31:0]        x2;
  logic [30:0]        ms;
  logic [30:0]        mc;
  logic [31:0]        vs;
  logic [31:0]        vc;
  logic [31:0]        es;
  logic [31:0]        ec;
  logic signed [33:0] sacc;
  logic signed [33:0] cacc;
  logic [3:0]         k;

  logic [60:0] prod_x;
  logic [61:0] prod_sq;
  logic [62:0] prod_vs;
  logic [62:0] prod_vc;
  logic [63:0] prod_es;
  logic [63:0] prod_ec;
  logic [40:0] back_s;
  logic [40:0] back_c;
  logic [31:0] rem_s;
  logic [31:0] rem_c;
  logic [31:0] ms_next;
  logic [31:0] mc_next;
  logic signed [33:0] ms_ext;
  logic signed [33:0] mc_ext;
  logic signed [33:0] s_q;
  logic signed [33:0] c_q;

  always_comb begin
    prod_x  = 61'(rr) * 61'(HALF_PI_Q30);
    prod_sq = 62'(x) * 62'(x);
    prod_vs = 63'(ms) * 63'(x2);
    prod_vc = 63'(mc) * 63'(x2);
    prod_es = 64'(vs) * 64'(sin_recip(k));
    prod_ec = 64'(vc) * 64'(cos_recip(k));
    back_s  = 41'(es) * 41'(sin_div(k));
    back_c  = 41'(ec) * 41'(cos_div(k));
    // estimate is at most one low; one compare fixes it
    rem_s   = vs - back_s[31:0];
    rem_c   = vc - back_c[31:0];
    ms_next = es + ((rem_s >= 32'(sin_div(k))) ? 32'd1 : 32'd0);
    mc_next = ec + ((rem_c >= 32'(cos_div(k))) ? 32'd1 : 32'd0);
    ms_ext  = signed'({3'b000, ms});
    mc_ext  = signed'({3'b000, mc});
    case (quad)
      2'd0:    begin s_q = sacc;  c_q = cacc;  end
      2'd1:    begin s_q = cacc;  c_q = -sacc; end
      2'd2:    begin s_q = -sacc; c_q = -cacc; end
      default: begin s_q = -cacc; c_q = sacc;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
      k     <= '0;
    end else begin
      done <= (state == T_FIN);
      case (state)
        T_IDLE: begin
          if (start) begin
            quad  <= phase[31:30];
            rr    <= phase[29:0];
            state <= T_X;
          end
        end
        T_X: begin
          x     <= prod_x[60:30];
          state <= T_SQ;
        end
        T_SQ: begin
          x2    <= prod_sq[61:30];
          ms    <= x;
          mc    <= ONE_Q30;
          sacc  <= '0;
          cacc  <= '0;
          k     <= '0;
          state <= T_ADD;
        end
        T_ADD: begin
          sacc <= k[0] ? sacc - ms_ext : sacc + ms_ext;
          cacc <= k[0] ? cacc - mc_ext : cacc + mc_ext;
          if (k == LAST_TERM) begin
            state <= T_FIN;
          end else begin
            vs    <= prod_vs[61:30];
            vc    <= prod_vc[61:30];
            state <= T_EST;
          end
        end
        T_EST: begin
          es    <= prod_es[63:32];
          ec    <= prod_ec[63:32];
          state <= T_COR;
        end
        T_COR: begin
          ms    <= ms_next[30:0];
          mc    <= mc_next[30:0];
          k     <= k + 4'd1;
          state <= T_ADD;
        end
        T_FIN: begin
          sin_q30 <= clamp_q30(s_q);
          cos_q30 <= clamp_q30(c_q);
          state   <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

[design/uvs_back.sv]
// Back end: angle and texture division, two trig units, position rounding,
// and the result buffer that emits the vertex and its triangles.
// Uses uvs_pkg and instantiates uvs_trig.
module uvs_back import uvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  uvs_item_t          q_item,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_TRIG, B_MUL, B_RND} back_state_t;
  typedef enum logic [1:0] {E_VERT, E_TRI1, E_TRI2} emit_t;

  back_state_t state;
  emit_t       emit;
  uvs_item_t   cur;
  logic [3:0]  div_cnt;
  logic        trig_go;

  logic [DIV_W-1:0] num [DIV_LANES];
  logic [6:0]       rem [DIV_LANES];
  logic [DIV_W-1:0] quo [DIV_LANES];
  logic [DIV_W-1:0] num_next [DIV_LANES];
  logic [6:0]       rem_next [DIV_LANES];
  logic [DIV_W-1:0] quo_next [DIV_LANES];
  logic [DIV_W-1:0] num_init [DIV_LANES];
  logic [7:0]       col_wrap;

  logic               done_a;
  logic               done_b;
  logic signed [31:0] sa;
  logic signed [31:0] ca;
  logic signed [31:0] sb;
  logic signed [31:0] cb;

  logic [30:0] mag_sa;
  logic [30:0] mag_ca;
  logic [30:0] mag_sb;
  logic [30:0] mag_cb;
  logic [61:0] mx;
  logic [61:0] mz;
  logic [30:0] my;
  logic        nx;
  logic        ny;
  logic        nz;
  logic [61:0] sum_x;
  logic [61:0] sum_z;
  logic [31:0] sum_y;

  logic        hold_valid;
  logic [15:0] hold_px;
  logic [15:0] hold_py;
  logic [15:0] hold_pz;
  logic [15:0] hold_tu;
  logic [15:0] hold_tv;
  logic [14:0] hold_k1;
  logic [14:0] hold_k2;
  logic        hold_tri_a;
  logic        hold_tri_b;

  logic [14:0] ca_a;
  logic [14:0] cb_a;
  logic [14:0] cc_a;
  logic [14:0] ca_b;
  logic [14:0] cb_b;
  logic [14:0] cc_b;
  logic [14:0] corner_a;
  logic [14:0] corner_b;
  logic [14:0] corner_c;
  logic        is_vertex;

  // numerators: angle a = i/(2S) turn, angle b = (j mod T)/T turn,
  // tex_v = i/S and tex_u = j/T in Q15, all rounded by adding half the divisor
  always_comb begin
    col_wrap    = (q_item.col == q_item.sectors) ? 8'd0 : q_item.col;
    num_init[0] = {1'b0, q_item.row, 31'd0} + DIV_W'(q_item.stacks >> 1);
    num_init[1] = {col_wrap, 32'd0} + DIV_W'(q_item.sectors >> 1);
    num_init[2] = {17'd0, q_item.row, 15'd0} + DIV_W'(q_item.stacks >> 1);
    num_init[3] = {17'd0, q_item.col, 15'd0} + DIV_W'(q_item.sectors >> 1);
  end

  // radix-16 restoring division, four narrow steps per cycle per lane
  always_comb begin
    logic [DIV_W-1:0] n;
    logic [DIV_W-1:0] qq;
    logic [7:0]       t;
    logic [7:0]       d;
    logic [6:0]       r;
    for (int l = 0; l < DIV_LANES; l++) begin
      n  = num[l];
      qq = quo[l];
      r  = rem[l];
      d  = l[0] ? cur.sectors : cur.stacks;
      for (int s = 0; s < DIV_STEP; s++) begin
        t = {r, n[DIV_W-1]};
        n = {n[DIV_W-2:0], 1'b0};
        if (t >= d) begin
          t  = t - d;
          qq = {qq[DIV_W-2:0], 1'b1};
        end else begin
          qq = {qq[DIV_W-2:0], 1'b0};
        end
        r = t[6:0];
      end
      num_next[l] = n;
      quo_next[l] = qq;
      rem_next[l] = r;
    end
  end

  uvs_trig u_trig_a (
    .clk     (clk),
    .rst     (rst),
    .start   (trig_go),
    .phase   (quo[0][31:0]),
    .done    (done_a),
    .sin_q30 (sa),
    .cos_q30 (ca)
  );

  uvs_trig u_trig_b (
    .clk     (clk),
    .rst     (rst),
    .start   (trig_go),
    .phase   (quo[1][31:0]),
    .done    (done_b),
    .sin_q30 (sb),
    .cos_q30 (cb)
  );

  always_comb begin
    mag_sa = sa[31] ? 31'(-sa) : sa[30:0];
    mag_ca = ca[31] ? 31'(-ca) : ca[30:0];
    mag_sb = sb[31] ? 31'(-sb) : sb[30:0];
    mag_cb = cb[31] ? 31'(-cb) : cb[30:0];
    sum_x  = mx + (62'd1 << (POS_SHIFT - 1));
    sum_z  = mz + (62'd1 << (POS_SHIFT - 1));
    sum_y  = {1'b0, my} + (32'd1 << (Y_SHIFT - 1));
  end

  assign q_pop = (state == B_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      emit       <= E_VERT;
      trig_go    <= 1'b0;
      hold_valid <= 1'b0;
      div_cnt    <= '0;
    end else begin
      trig_go <= (state == B_DIV) && (div_cnt == 4'(DIV_CYCLES - 1));
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            cur     <= q_item;
            div_cnt <= '0;
            for (int l = 0; l < DIV_LANES; l++) begin
              num[l] <= num_init[l];
              rem[l] <= '0;
              quo[l] <= '0;
            end
            state <= B_DIV;
          end
        end
        B_DIV: begin
          for (int l = 0; l < DIV_LANES; l++) begin
            num[l] <= num_next[l];
            rem[l] <= rem_next[l];
            quo[l] <= quo_next[l];
          end
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'(DIV_CYCLES - 1)) begin
            state <= B_TRIG;
          end
        end
        B_TRIG: begin
          if (done_a) state <= B_MUL;
        end
        B_MUL: begin
          mx    <= 62'(mag_sa) * 62'(mag_cb);
          mz    <= 62'(mag_sa) * 62'(mag_sb);
          my    <= mag_ca;
          nx    <= sa[31] ^ cb[31];
          nz    <= sa[31] ^ sb[31];
          ny    <= ca[31];
          state <= B_RND;
        end
        B_RND: begin
          if (!hold_valid) begin
            hold_px    <= round_sat16(sum_x[61:POS_SHIFT], nx);
            hold_pz    <= round_sat16(sum_z[61:POS_SHIFT], nz);
            hold_py    <= round_sat16(sum_y[31:Y_SHIFT], ny);
            hold_tu    <= quo[3][15:0];
            hold_tv    <= quo[2][15:0];
            hold_k1    <= cur.k1;
            hold_k2    <= cur.k2;
            hold_tri_a <= cur.tri_a;
            hold_tri_b <= cur.tri_b;
            hold_valid <= 1'b1;
            emit       <= E_VERT;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase

      // result buffer drains while the engine works on the next point
      if (hold_valid && m_tready) begin
        if (m_tlast) begin
          hold_valid <= 1'b0;
        end else begin
          case (emit)
            E_VERT:  emit <= E_TRI1;
            default: emit <= E_TRI2;
          endcase
        end
      end
    end
  end

  always_comb begin
    ca_a = hold_k1 + 15'd1;
    cb_a = hold_k2;
    cc_a = hold_k1;
    ca_b = hold_k2 + 15'd1;
    cb_b = hold_k2;
    cc_b = hold_k1 + 15'd1;
    case (emit)
      E_VERT: begin
        is_vertex = 1'b1;
        m_tlast   = !(hold_tri_a || hold_tri_b);
        corner_a  = '0;
        corner_b  = '0;
        corner_c  = '0;
      end
      E_TRI1: begin
        is_vertex = 1'b0;
        m_tlast   = !(hold_tri_a && hold_tri_b);
        corner_a  = hold_tri_a ? ca_a : ca_b;
        corner_b  = hold_tri_a ? cb_a : cb_b;
        corner_c  = hold_tri_a ? cc_a : cc_b;
      end
      default: begin
        is_vertex = 1'b0;
        m_tlast   = 1'b1;
        corner_a  = ca_b;
        corner_b  = cb_b;
        corner_c  = cc_b;
      end
    endcase
    m_tvalid = hold_valid;
    m_tuser  = !is_vertex;
    if (is_vertex) begin
      m_tdata = {3'd0, 45'd0, hold_tv, hold_tu, hold_pz, hold_py, hold_px};
    end else begin
      m_tdata = {3'd0, corner_c, corner_b, corner_a, 80'd0};
    end
  end

`ifndef SYNTHESIS
  a_trig_lockstep: assert property (@(posedge clk) disable iff (rst)
    done_a == done_b)
    else $error("trig units out of step");

  a_tri2_last: assert property (@(posedge clk) disable iff (rst)
    hold_valid && emit == E_TRI2 |-> m_tlast && hold_tri_a && hold_tri_b)
    else $error("second triangle without both triangles");

  a_go_in_trig: assert property (@(posedge clk) disable iff (rst)
    trig_go |-> state == B_TRIG)
    else $error("trig start outside trig phase");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == B_DIV |-> div_cnt < 4'(DIV_CYCLES))
    else $error("divider ran past its last digit");
`endif

endmodule

[design/uv_sphere_vertex_and_triangle_gen.sv]
// UV sphere grid point generator: vertex position, texture coordinates
// and up to two triangles per accepted (row, column) transaction.
// Grid points pass one at a time through the radix-16 divider and the
// Taylor series loop; the next point starts while results still drain.
// Reset (rst, synchronous) loads 16 stacks / 32 sectors and empties the queue.
module uv_sphere_vertex_and_triangle_gen import uvs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]            cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,  // row_index[7:0], column_index[15:8]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pos_x[15:0], pos_y[31:16], pos_z[47:32], tex_u[63:48], tex_v[79:64],
  // corner_a[94:80], corner_b[109:95], corner_c[124:110], zero[127:125]
  output logic [TDATA_W-1:0]    m_tdata,
  output logic                  m_tuser,  // is_triangle
  output logic                  m_tlast   // last_of_run
);

  uvs_item_t push_item;
  uvs_item_t pop_item;
  logic      push;
  logic      q_ready;
  logic      q_valid;
  logic      q_pop;

  uvs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_row    (s_tdata[7:0]),
    .in_col    (s_tdata[15:8]),
    .q_ready   (q_ready),
    .push      (push),
    .item      (push_item)
  );

  uvs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .ready     (q_ready),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .valid     (q_valid)
  );

  uvs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (pop_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[dv/uv_sphere_vertex_and_triangle_gen_tb.sv]
// Self-checking bench for the UV sphere vertex and triangle generator.
// Drives grid points and register writes, predicts vertices and triangles.
// Depends on uvs_pkg and the RTL top level.
module uv_sphere_vertex_and_triangle_gen_tb;
  import uvs_pkg::*;

  typedef struct {
    logic        tri_flag;
    logic [15:0] px, py, pz, tu, tv;
    logic [14:0] ca, cb, cc;
    logic        last;
  } mesh_rec_t;

  class mesh_scoreboard;
    mesh_rec_t pending[$];
    logic [7:0] stacks_reg = STACK_COUNT_RESET;
    logic [7:0] sectors_reg = SECTOR_COUNT_RESET;
    int errors = 0;

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function void expect_rec(mesh_rec_t r);
      pending = {pending, r};
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
      if (idx == CFG_STACK_COUNT) stacks_reg = val;
      else if (idx == CFG_SECTOR_COUNT) sectors_reg = val;
    endfunction

    // Taylor sin/cos of a Q0.32 turn, Q30 results
    function void sincos(input logic [31:0] p, output longint s_o, output longint c_o);
      logic [1:0] q;
      longint unsigned r, x, x2, ms, mc;
      longint s, c, ts, tc;
      q = p[31:30];
      r = p[29:0];
      x = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      ms = x; mc = 64'd1 << 30; s = 0; c = 0;
      for (int k = 0; k < 10; k++) begin
        if (k % 2 == 0) begin s += ms; c += mc; end
        else begin s -= ms; c -= mc; end
        ms = ((ms * x2) >> 30) / ((2 * k + 2) * (2 * k + 3));
        mc = ((mc * x2) >> 30) / ((2 * k + 1) * (2 * k + 2));
      end
      case (q)
        2'd0: begin ts = s; tc = c; end
        2'd1: begin ts = c; tc = -s; end
        2'd2: begin ts = -s; tc = -c; end
        default: begin ts = -c; tc = s; end
      endcase
      s_o = ts > (64'sd1 <<< 30) ? (64'sd1 <<< 30) : ts < -(64'sd1 <<< 30) ? -(64'sd1 <<< 30) : ts;
      c_o = tc > (64'sd1 <<< 30) ? (64'sd1 <<< 30) : tc < -(64'sd1 <<< 30) ? -(64'sd1 <<< 30) : tc;
    endfunction

    function logic [15:0] to_q15(longint v, int sh);
      longint unsigned m;
      m = v < 0 ? -v : v;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      if (v < 0) return m > 32768 ? 16'h8000 : 16'(-m);
      return m > 32767 ? 16'h7fff : 16'(m);
    endfunction

    function logic [15:0] tex(longint unsigned n, longint unsigned d);
      longint unsigned t;
      t = ((n << FRAC_BITS) + d / 2) / d;
      return t > 65535 ? 16'hffff : 16'(t);
    endfunction

    function void note_point(logic [7:0] row, logic [7:0] col);
      longint unsigned st, se, k1, k2;
      longint sa, ca, sb, cb;
      mesh_rec_t v, t;
      st = stacks_reg < 2 ? 2 : stacks_reg > MAX_STACKS ? MAX_STACKS : stacks_reg;
      se = sectors_reg < 3 ? 3 : sectors_reg > MAX_SECTORS ? MAX_SECTORS : sectors_reg;
      if (row > st || col > se) return;
      sincos(32'(((longint'(row) << 31) + st / 2) / st), sa, ca);
      sincos(32'((((col % se) << 32) + se / 2) / se), sb, cb);
      v = '{1'b0, to_q15(sa * cb, POS_SHIFT), to_q15(ca, Y_SHIFT), to_q15(sa * sb, POS_SHIFT),
            tex(col, se), tex(row, st), 15'd0, 15'd0, 15'd0, 1'b1};
      t = '{1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0, 15'd0, 1'b0};
      if (row < st && col < se) begin
        k1 = row * (se + 1) + col;
        k2 = k1 + se + 1;
        if (row != 0 || row != st - 1) v.last = 1'b0;
        expect_rec(v);
        if (row != 0) begin
          t.ca = 15'(k1 + 1); t.cb = 15'(k2); t.cc = 15'(k1);
          t.last = (row == st - 1);
          expect_rec(t);
        end
        if (row != st - 1) begin
          t.ca = 15'(k2 + 1); t.cb = 15'(k2); t.cc = 15'(k1 + 1); t.last = 1'b1;
          expect_rec(t);
        end
      end else expect_rec(v);
    endfunction

    function void check_result(logic [TDATA_W-1:0] d, logic tu, logic tl);
      mesh_rec_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      e = pending.pop_front();
      if (tu !== e.tri_flag) report($sformatf("is_triangle %b exp %b", tu, e.tri_flag));
      if (tl !== e.last) report($sformatf("last_of_run %b exp %b", tl, e.last));
      if (d[15:0] !== e.px) report($sformatf("pos_x %h exp %h", d[15:0], e.px));
      if (d[31:16] !== e.py) report($sformatf("pos_y %h exp %h", d[31:16], e.py));
      if (d[47:32] !== e.pz) report($sformatf("pos_z %h exp %h", d[47:32], e.pz));
      if (d[63:48] !== e.tu) report($sformatf("tex_u %h exp %h", d[63:48], e.tu));
      if (d[79:64] !== e.tv) report($sformatf("tex_v %h exp %h", d[79:64], e.tv));
      if (d[94:80] !== e.ca) report($sformatf("corner_a %h exp %h", d[94:80], e.ca));
      if (d[109:95] !== e.cb) report($sformatf("corner_b %h exp %h", d[109:95], e.cb));
      if (d[124:110] !== e.cc) report($sformatf("corner_c %h exp %h", d[124:110], e.cc));
      if (d[127:125] !== 3'd0) report("tdata pad bits not zero");
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [7:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;  // row_index[7:0], column_index[15:8]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;  // pos_x .. corner_c, see RTL port list
  logic m_tuser;  // is_triangle
  logic m_tlast;  // last_of_run

  mesh_scoreboard mesh_sb = new();
  int cycle_count = 0;
  bit calm = 1'b0;  // no idling on either side while set
  localparam int CYCLE_LIMIT = 2000000;

  uv_sphere_vertex_and_triangle_gen u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("uv_sphere_vertex_and_triangle_gen regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) mesh_sb.check_result(m_tdata, m_tuser, m_tlast);
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
  end

  task automatic write_cfg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    mesh_sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // s_tvalid stays high between back-to-back transactions
  task automatic send_point(logic [7:0] row, logic [7:0] col);
    if (!calm && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 17) @(posedge clk);
    end
    s_tvalid <= 1'b1; s_tdata <= {col, row};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mesh_sb.note_point(row, col);
  endtask

  // wait for the queue to drain, then cover the block's pipeline latency
  task automatic drain;
    s_tvalid <= 1'b0;
    while (mesh_sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic sweep_random(int n);
    logic [7:0] st, se;
    st = 8'(mesh_sb.stacks_reg < 2 ? 2 : mesh_sb.stacks_reg > 128 ? 128 : mesh_sb.stacks_reg);
    se = 8'(mesh_sb.sectors_reg < 3 ? 3 : mesh_sb.sectors_reg > 128 ? 128 : mesh_sb.sectors_reg);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0)
        send_point(8'($urandom_range(255)), 8'($urandom_range(255)));
      else send_point(8'($urandom_range(st)), 8'($urandom_range(se)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset registers: poles, seam, last row/column, out of range
    send_point(0, 0); send_point(1, 5); send_point(15, 31); send_point(16, 0);
    send_point(8, 32); send_point(16, 32); send_point(17, 0); send_point(0, 33);
    send_point(255, 255); send_point(4, 8); send_point(12, 24);
    drain();
    write_cfg(CFG_STACK_COUNT, 8'd2); write_cfg(CFG_SECTOR_COUNT, 8'd3);
    send_point(0, 0); send_point(1, 1); send_point(2, 3); send_point(1, 2);
    drain();
    write_cfg(CFG_STACK_COUNT, 8'd128); write_cfg(CFG_SECTOR_COUNT, 8'd128);
    send_point(128, 128); send_point(127, 127); send_point(64, 127); send_point(129, 0);
    drain();
    // out-of-range registers are clamped when used
    write_cfg(CFG_STACK_COUNT, 8'd0); write_cfg(CFG_SECTOR_COUNT, 8'd255);
    send_point(1, 127); send_point(2, 128); send_point(0, 200);
    drain();
    write_cfg(CFG_STACK_COUNT, 8'd7); write_cfg(CFG_SECTOR_COUNT, 8'd5);
    sweep_random(50);
    drain();
    write_cfg(CFG_STACK_COUNT, 8'($urandom_range(2, 128)));
    write_cfg(CFG_SECTOR_COUNT, 8'($urandom_range(3, 128)));
    calm = 1'b1;
    sweep_random(40);
    calm = 1'b0;
    drain();
    write_cfg(CFG_STACK_COUNT, 8'($urandom_range(255)));
    write_cfg(CFG_SECTOR_COUNT, 8'($urandom_range(255)));
    sweep_random(60);
    drain();
    if (mesh_sb.errors == 0 && mesh_sb.pending.size() == 0)
      $display("uv_sphere_vertex_and_triangle_gen regression: pass");
    else
      $display("uv_sphere_vertex_and_triangle_gen regression: fail");
    $finish;
  end
endmodule
